>>> rtl/sha256mh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher package
// Word type, controller states, initial hash value, round constants and the
// sigma and padding helper functions.
// ----------------------------------------------------------------------------
package sha256mh_pkg;

  typedef logic [31:0] word_t;

  // Controller states, one-hot coded.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PAD   = 7'b0000010,
    ST_PREP0 = 7'b0000100,
    ST_PREP1 = 7'b0001000,
    ST_RND   = 7'b0010000,
    ST_FIN   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  localparam word_t END_MARK = 32'h8000_0000;

  localparam word_t HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Upper-case sigma functions of the round.
  function automatic word_t bsig0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Lower-case sigma functions of the message schedule.
  function automatic word_t ssig0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t ssig1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  // Message bytes kept in a short final word.
  function automatic word_t keep_mask(logic [1:0] n);
    word_t m;
    unique case (n)
      2'd0:    m = 32'h0000_0000;
      2'd1:    m = 32'hFF00_0000;
      2'd2:    m = 32'hFFFF_0000;
      default: m = 32'hFFFF_FF00;
    endcase
    return m;
  endfunction

  // End marker placed right after the last message byte.
  function automatic word_t end_marker(logic [1:0] n);
    word_t m;
    unique case (n)
      2'd0:    m = 32'h8000_0000;
      2'd1:    m = 32'h0080_0000;
      2'd2:    m = 32'h0000_8000;
      default: m = 32'h0000_0080;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Collects big-endian message words into a 16-entry schedule memory, pads the
// message and runs the 64-round compression, then emits the eight digest words.
// ----------------------------------------------------------------------------
// A word that neither fills a block nor ends the message leaves busy low; a word
//   that fills a block holds busy through read-ahead (PREP0, PREP1), the rounds
//   and the hash update (FIN). The compression runs one round per cycle out of
//   the schedule memory, and no new word is taken until it is done.
// A last word adds padding and one or two compressions, then the eight digest
//   words leave on consecutive cycles; the receiver cannot stall.
// Reset (rst_n low, synchronous) restores the initial hash value and clears
//   the counters; the schedule memory is not cleared.
module sha256_message_hasher (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  sha256mh_pkg::word_t  in_data_word,
  input  logic [2:0]           in_valid_bytes,
  input  logic                 in_last_word,
  output logic                 out_strobe,
  output sha256mh_pkg::word_t  out_digest_word,
  output logic [2:0]           out_word_index,
  output logic                 out_last_of_run
);
  import sha256mh_pkg::*;

  // Control registers.
  state_t      state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [60:0] bytes_r, bytes_nxt;
  logic        marker_r, marker_nxt;
  logic        hi_done_r, hi_done_nxt;
  logic        final_r, final_nxt;
  logic        pad_r, pad_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [5:0]  sched_r, sched_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  word_t       hash_r [8];
  word_t       hash_nxt [8];
  logic        ostb_r;

  // Datapath registers.
  word_t       wmem [16];
  word_t       rd_a_r, rd_b_r;
  word_t       w1_r, w2_r, w16_r, kw_r;
  word_t       wv_r [8];
  word_t       odata_r;
  logic [2:0]  oidx_q_r;
  logic        olast_r;

  logic        accept;
  logic [2:0]  nbytes;
  word_t       in_word;
  word_t       pad_word;
  logic        mem_we;
  logic [3:0]  mem_waddr;
  word_t       mem_wdata;
  logic [5:0]  rd_idx;
  logic [3:0]  rd_a_addr, rd_b_addr;
  word_t       w_new;
  logic        sched_go;
  word_t       t_one, t_two;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Valid byte count, saturated at four.
  assign nbytes = in_valid_bytes[2] ? 3'd4 : in_valid_bytes;

  // Word written on input: short last words are masked and get the end marker.
  always_comb begin
    if (!in_last_word || nbytes == 3'd4) begin
      in_word = in_data_word;
    end else begin
      in_word = (in_data_word & keep_mask(nbytes[1:0])) | end_marker(nbytes[1:0]);
    end
  end

  // Padding word: marker, zeros, then the bit length with its high word first.
  always_comb begin
    priority if (marker_r) begin
      pad_word = END_MARK;
    end else if (cnt_r == 4'd14) begin
      pad_word = bytes_r[60:29];
    end else if (cnt_r == 4'd15 && hi_done_r) begin
      pad_word = {bytes_r[28:0], 3'b000};
    end else begin
      pad_word = '0;
    end
  end

  // Schedule read-ahead: port A gives w[j] for j < 16 and w[j-7] after that,
  // port B gives w[j-15]. Writes of the cycle never hit the slots being read.
  assign rd_idx    = (state_r == ST_PREP0) ? 6'd0 : sched_r + 6'd1;
  assign rd_a_addr = (rd_idx < 6'd16) ? rd_idx[3:0] : rd_idx[3:0] + 4'd9;
  assign rd_b_addr = rd_idx[3:0] + 4'd1;

  // Schedule word j; w16_r holds w[j-16] from the previous port B read.
  assign sched_go = (state_r == ST_PREP1) || (state_r == ST_RND && rnd_r != 6'd63);
  always_comb begin
    if (sched_r < 6'd16) begin
      w_new = rd_a_r;
    end else begin
      w_new = w16_r + ssig0(rd_b_r) + rd_a_r + ssig1(w2_r);
    end
  end

  // Memory write port: input words, padding words or expanded schedule words.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = in_word;
    if (state_r == ST_IDLE) begin
      mem_we = accept;
    end else if (state_r == ST_PAD) begin
      mem_we    = 1'b1;
      mem_wdata = pad_word;
    end else if (sched_go && sched_r >= 6'd16) begin
      mem_we    = 1'b1;
      mem_waddr = sched_r[3:0];
      mem_wdata = w_new;
    end
  end

  // Schedule memory: one write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      wmem[mem_waddr] <= mem_wdata;
    end
    rd_a_r <= wmem[rd_a_addr];
    rd_b_r <= wmem[rd_b_addr];
  end

  // Schedule pipeline; kw_r carries K plus the word into the next round.
  always_ff @(posedge clk) begin
    if (sched_go) begin
      w1_r  <= w_new;
      w2_r  <= w1_r;
      w16_r <= rd_b_r;
      kw_r  <= ROUND_K[sched_r] + w_new;
    end
  end

  // Compression round on the working variables.
  assign t_one = wv_r[7] + bsig1(wv_r[4]) + ((wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]))
                 + kw_r;
  assign t_two = bsig0(wv_r[0])
                 + ((wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]));

  always_ff @(posedge clk) begin
    if (state_r == ST_PREP1) begin
      wv_r <= hash_r;
    end else if (state_r == ST_RND) begin
      wv_r[7] <= wv_r[6];
      wv_r[6] <= wv_r[5];
      wv_r[5] <= wv_r[4];
      wv_r[4] <= wv_r[3] + t_one;
      wv_r[3] <= wv_r[2];
      wv_r[2] <= wv_r[1];
      wv_r[1] <= wv_r[0];
      wv_r[0] <= t_one + t_two;
    end
  end

  // Controller next state.
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    bytes_nxt   = bytes_r;
    marker_nxt  = marker_r;
    hi_done_nxt = hi_done_r;
    final_nxt   = final_r;
    pad_nxt     = pad_r;
    rnd_nxt     = rnd_r;
    sched_nxt   = sched_r;
    oidx_nxt    = oidx_r;
    hash_nxt    = hash_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = cnt_r + 4'd1;
          if (in_last_word) begin
            bytes_nxt   = bytes_r + 61'(nbytes);
            marker_nxt  = (nbytes == 3'd4);
            pad_nxt     = 1'b1;
            hi_done_nxt = 1'b0;
            final_nxt   = 1'b0;
          end else begin
            bytes_nxt = bytes_r + 61'd4;
          end
          if (cnt_r == 4'd15) begin
            state_nxt = ST_PREP0;
          end else if (in_last_word) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cnt_nxt = cnt_r + 4'd1;
        priority if (marker_r) begin
          marker_nxt = 1'b0;
        end else if (cnt_r == 4'd14) begin
          hi_done_nxt = 1'b1;
        end else if (cnt_r == 4'd15 && hi_done_r) begin
          final_nxt = 1'b1;
        end else begin
          hi_done_nxt = hi_done_r;
        end
        if (cnt_r == 4'd15) begin
          state_nxt = ST_PREP0;
        end
      end
      ST_PREP0: begin
        sched_nxt = '0;
        state_nxt = ST_PREP1;
      end
      ST_PREP1: begin
        sched_nxt = sched_r + 6'd1;
        rnd_nxt   = '0;
        state_nxt = ST_RND;
      end
      ST_RND: begin
        sched_nxt = sched_r + 6'd1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = hash_r[i] + wv_r[i];
        end
        rnd_nxt = '0;
        if (final_r) begin
          oidx_nxt  = '0;
          state_nxt = ST_OUT;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        oidx_nxt = oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          hash_nxt    = HASH_INIT;
          cnt_nxt     = '0;
          bytes_nxt   = '0;
          marker_nxt  = 1'b0;
          hi_done_nxt = 1'b0;
          final_nxt   = 1'b0;
          pad_nxt     = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Controller registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      bytes_r   <= '0;
      marker_r  <= 1'b0;
      hi_done_r <= 1'b0;
      final_r   <= 1'b0;
      pad_r     <= 1'b0;
      rnd_r     <= '0;
      sched_r   <= '0;
      oidx_r    <= '0;
      hash_r    <= HASH_INIT;
      ostb_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      bytes_r   <= bytes_nxt;
      marker_r  <= marker_nxt;
      hi_done_r <= hi_done_nxt;
      final_r   <= final_nxt;
      pad_r     <= pad_nxt;
      rnd_r     <= rnd_nxt;
      sched_r   <= sched_nxt;
      oidx_r    <= oidx_nxt;
      hash_r    <= hash_nxt;
      ostb_r    <= (state_r == ST_OUT);
    end
  end

  // Digest output register, one word per cycle.
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT) begin
      odata_r  <= hash_r[oidx_r];
      oidx_q_r <= oidx_r;
      olast_r  <= (oidx_r == 3'd7);
    end
  end

  assign out_strobe      = ostb_r;
  assign out_digest_word = odata_r;
  assign out_word_index  = oidx_q_r;
  assign out_last_of_run = olast_r;

endmodule

>>> rtl/sha256mh_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher port checker
// Watches the digest word sequence and busy on the top level's ports.
// ----------------------------------------------------------------------------
module sha256mh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_strobe,
  input logic [2:0]  out_word_index,
  input logic        out_last_of_run
);

  // A digest run starts at word zero.
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe) |-> out_word_index == 3'd0)
    else $error("digest run does not start at word zero");

  // Words of a run follow on consecutive cycles until the last one.
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_of_run |=> out_strobe)
    else $error("gap inside a digest run");

  // Word index counts up by one inside a run.
  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_of_run |=> out_word_index == 3'($past(out_word_index) + 3'd1))
    else $error("digest word index out of order");

  // The last word of a run is word seven.
  a_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_of_run |-> out_word_index == 3'd7)
    else $error("last digest word is not word seven");

  // No new word is taken while a run is still going out.
  a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_of_run |-> busy)
    else $error("block idle during a digest run");

endmodule

bind sha256_message_hasher sha256mh_checker u_sha256mh_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_word_index  (out_word_index),
  .out_last_of_run (out_last_of_run)
);

>>> verif/sha256_message_hasher_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher checker
// Watches the word and digest channels of the hasher, keeps its own SHA-256
// state to work out the digest of every message, and compares each digest
// word that leaves the block with the oldest one still expected.
// ----------------------------------------------------------------------------
module sha256_message_hasher_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  sha256mh_pkg::word_t  in_data_word,
  input  logic [2:0]           in_valid_bytes,
  input  logic                 in_last_word,
  input  logic                 out_strobe,
  input  sha256mh_pkg::word_t  out_digest_word,
  input  logic [2:0]           out_word_index,
  input  logic                 out_last_of_run,
  output int                   fail_count,
  output int                   digests_waiting
);

  timeunit 1ns;
  timeprecision 1ps;

  import sha256mh_pkg::word_t;

  localparam word_t PAD_MARK = 32'h8000_0000;

  localparam word_t SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    word_t      digest;
    logic [2:0] idx;
    logic       fin;
  } digest_entry_t;

  // Running hash of the current message.
  word_t         chain [8];
  word_t         blk [16];
  int unsigned   fill;
  logic [60:0]   msg_bytes;
  digest_entry_t digest_q [$];

  function automatic word_t ror(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression of the collected block into the chain value.
  task automatic compress_block();
    word_t w [64];
    word_t v [8];
    word_t t1, t2;
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        w[r] = blk[r];
      end else begin
        w[r] = w[r-16] + w[r-7]
             + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3))
             + (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10));
      end
    end
    v = chain;
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) begin
      chain[j] = chain[j] + v[j];
    end
  endtask

  task automatic absorb_word(word_t x);
    blk[fill] = x;
    fill++;
    if (fill == 16) begin
      compress_block();
      fill = 0;
    end
  endtask

  task automatic restart_message();
    chain = SHA_IV;
    fill = 0;
    msg_bytes = '0;
  endtask

  // Takes one accepted word; a last word pads the message and queues its digest.
  task automatic hash_word(word_t data, logic [2:0] nb, logic last);
    int unsigned n;
    logic [63:0] bit_len;
    if (!last) begin
      // Words before the last always carry four bytes.
      msg_bytes = msg_bytes + 61'd4;
      absorb_word(data);
    end else begin
      n = (nb > 3'd4) ? 4 : nb;
      msg_bytes = msg_bytes + 61'(n);
      if (n == 4) begin
        absorb_word(data);
        absorb_word(PAD_MARK);
      end else begin
        absorb_word((data & ~(32'hFFFF_FFFF >> (8 * n))) | (PAD_MARK >> (8 * n)));
      end
      while (fill != 14) begin
        absorb_word('0);
      end
      bit_len = {msg_bytes, 3'b000};
      absorb_word(bit_len[63:32]);
      absorb_word(bit_len[31:0]);
      for (int j = 0; j < 8; j++) begin
        digest_q.push_back('{digest: chain[j], idx: 3'(j), fin: (j == 7)});
      end
      restart_message();
    end
  endtask

  initial begin
    fail_count = 0;
    digests_waiting = 0;
    restart_message();
  end

  // Compare digest words first, then take in any word accepted at this edge.
  always @(posedge clk) begin
    digest_entry_t e;
    if (!rst_n) begin
      restart_message();
      digest_q.delete();
    end else begin
      if (out_strobe) begin
        if (digest_q.size() == 0) begin
          $display("%0t: digest word %08h index %0d with none expected",
                   $time, out_digest_word, out_word_index);
          fail_count++;
        end else begin
          e = digest_q.pop_front();
          if (out_digest_word !== e.digest) begin
            $display("%0t: digest word: expected %08h, actual %08h",
                     $time, e.digest, out_digest_word);
            fail_count++;
          end
          if (out_word_index !== e.idx) begin
            $display("%0t: word index: expected %0d, actual %0d",
                     $time, e.idx, out_word_index);
            fail_count++;
          end
          if (out_last_of_run !== e.fin) begin
            $display("%0t: last of run: expected %0b, actual %0b",
                     $time, e.fin, out_last_of_run);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        hash_word(in_data_word, in_valid_bytes, in_last_word);
      end
    end
    digests_waiting = digest_q.size();
  end

endmodule

>>> verif/sha256_message_hasher_test.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Sends directed and random messages word by word with random gaps, and lets
// the checker compare every digest word against its own SHA-256 computation.
// ----------------------------------------------------------------------------
module sha256_message_hasher_test;

  timeunit 1ns;
  timeprecision 1ps;

  import sha256mh_pkg::word_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int WORD_TARGET = 180;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  word_t      in_data_word = '0;
  logic [2:0] in_valid_bytes = '0;
  logic       in_last_word = 1'b0;
  logic       out_strobe;
  word_t      out_digest_word;
  logic [2:0] out_word_index;
  logic       out_last_of_run;
  int         fail_count;
  int         digests_waiting;
  int         cycle_count = 0;
  int         words_sent = 0;
  bit         burst = 1'b0;

  sha256_message_hasher dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data_word    (in_data_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_last_word    (in_last_word),
    .out_strobe      (out_strobe),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_of_run (out_last_of_run)
  );

  sha256_message_hasher_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data_word    (in_data_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_last_word    (in_last_word),
    .out_strobe      (out_strobe),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_of_run (out_last_of_run),
    .fail_count      (fail_count),
    .digests_waiting (digests_waiting)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Drives one word after a random gap and holds it until the block takes it.
  task automatic send_word(word_t data, logic [2:0] nb, logic last);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_data_word <= data;
    in_valid_bytes <= nb;
    in_last_word <= last;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  function automatic word_t pick_data();
    word_t d;
    case ($urandom_range(0, 9))
      0:       d = '0;
      1:       d = '1;
      default: d = $urandom;
    endcase
    return d;
  endfunction

  // A message of full words followed by a last word with the given byte count.
  task automatic send_message(int full_words, logic [2:0] last_nb);
    logic [2:0] nb;
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < full_words; i++) begin
      // Mostly four bytes; now and then a random count that the block must ignore.
      nb = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      send_word(pick_data(), nb, 1'b0);
    end
    send_word(pick_data(), last_nb, 1'b1);
  endtask

  initial begin
    int full_words;
    logic [2:0] last_nb;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Empty message, the classic three-byte string, and each byte count from
    // zero to four on a single-word message, plus counts above four that saturate.
    send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
    send_word(32'h6162_6300, 3'd3, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd2, 1'b1);
    send_word(32'h0000_0000, 3'd4, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
    send_word(32'h1234_5678, 3'd5, 1'b1);

    // Short counts on words before the last, and a message whose padding
    // spills into an extra block.
    for (int i = 0; i < 13; i++) begin
      send_word(i[0] ? 32'h0000_0000 : 32'hFFFF_FFFF, 3'(i), 1'b0);
    end
    send_word(32'hA5A5_A5A5, 3'd6, 1'b1);

    // Random messages, with lengths clustered around the block boundary.
    while (words_sent < WORD_TARGET) begin
      full_words = ($urandom_range(0, 2) == 0) ? $urandom_range(12, 17)
                                               : $urandom_range(0, 34);
      last_nb = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(1, 4))
                                           : 3'($urandom_range(0, 7));
      send_message(full_words, last_nb);
    end

    @(negedge clk);
    start <= 1'b0;
    while (digests_waiting != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
